FILE: src/rrsd_pkg.sv
package rrsd_pkg;

   // fixed field widths
   localparam int ARRIVAL_W = 31;
   localparam int LOAD_W    = 31;
   localparam int COUNT_W   = 32;
   localparam int INDEX_W   = 4;
   localparam int NSRV_W    = 5;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;

   localparam int DEF_MAX_SERVERS = 16;
   localparam int DEF_TIME_BITS   = 32;

   // power of two
   localparam int QUEUE_DEPTH = 2;

   localparam logic [NSRV_W-1:0]  NSRV_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

   localparam logic KIND_DISPATCH = 1'b0;
   localparam logic KIND_REPORT   = 1'b1;

   typedef struct packed {
      logic [ARRIVAL_W-1:0] arrival;
      logic                 last;
   } front_item_type;

endpackage

FILE: src/rrsd_front.sv
module rrsd_front #(
   parameter int TIME_BITS = rrsd_pkg::DEF_TIME_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rrsd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   output logic                              q_valid,
   input  logic                              q_pop,
   output rrsd_pkg::front_item_type          q_item,
   output logic [TIME_BITS-1:0]              q_finish
);
   import rrsd_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [63:0] TIME_MAX =
      (TIME_BITS == 64) ? '1 : ((64'd1 << TIME_BITS) - 64'd1);

   front_item_type       item_ff [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] fin_ff  [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    cnt_ff, cnt_in;

   logic [ARRIVAL_W:0]   sum;
   logic [TIME_BITS-1:0] fin_new;
   front_item_type       item_new;
   logic                 push;

   assign req_tready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != '0);
   assign q_item     = item_ff[rd_ptr_ff];
   assign q_finish   = fin_ff[rd_ptr_ff];

   // finish time is worked out here so the back end only compares and writes
   always_comb begin
      sum = {1'b0, req_tdata[ARRIVAL_W-1:0]} +
            {1'b0, req_tdata[ARRIVAL_W+LOAD_W-1:ARRIVAL_W]};
      if (64'(sum) > TIME_MAX) begin
         fin_new = '1;
      end else begin
         fin_new = TIME_BITS'(sum);
      end
      item_new.arrival = req_tdata[ARRIVAL_W-1:0];
      item_new.last    = req_tlast;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= item_new;
         fin_ff[wr_ptr_ff]  <= fin_new;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> cnt_ff != '0)
      else $error("pop from empty queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> cnt_ff == $past(cnt_ff) + QCNT_W'(1))
      else $error("queue count did not follow push");

endmodule

FILE: src/rrsd_back.sv
module rrsd_back #(
   parameter int MAX_SERVERS = rrsd_pkg::DEF_MAX_SERVERS,
   parameter int TIME_BITS   = rrsd_pkg::DEF_TIME_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rrsd_pkg::NSRV_W-1:0]       csr_wdata,
   input  logic                              q_valid,
   output logic                              q_pop,
   input  rrsd_pkg::front_item_type          q_item,
   input  logic [TIME_BITS-1:0]              q_finish,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rrsd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import rrsd_pkg::*;

   localparam int SRV_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W = $clog2(MAX_SERVERS + 1);
   localparam int CMP_W = (TIME_BITS > ARRIVAL_W) ? TIME_BITS : ARRIVAL_W;

   typedef enum logic [1:0] {S_IDLE, S_PICK, S_MAX, S_LIST} state_type;

   state_type            state_ff, state_in;
   logic [NSRV_W-1:0]    nsrv_ff, nsrv_in;
   logic [TIME_BITS-1:0] finish_ff [MAX_SERVERS];
   logic [TIME_BITS-1:0] finish_in [MAX_SERVERS];
   logic [COUNT_W-1:0]   count_ff  [MAX_SERVERS];
   logic [COUNT_W-1:0]   count_in  [MAX_SERVERS];
   logic [SRV_W-1:0]     ptr_ff, ptr_in;
   logic [TIME_BITS-1:0] newfin_ff, newfin_in;
   logic                 last_ff, last_in;
   logic [MAX_SERVERS-1:0] free_ff, free_in;
   logic [SRV_W-1:0]     start_ff, start_in;
   logic [SRV_W-1:0]     scan_ff, scan_in;
   logic [COUNT_W-1:0]   best_ff, best_in;
   logic [SRV_W-1:0]     last_idx_ff, last_idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic                 rsp_acc_ff, rsp_acc_in;
   logic [INDEX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [COUNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [6:0]           k_wide;
   logic [CNT_W-1:0]     k;
   logic                 out_free;
   logic [SRV_W-1:0]     rd_idx;
   logic [COUNT_W-1:0]   count_rd;
   logic [COUNT_W-1:0]   count_inc;
   logic [SRV_W-1:0]     hi_idx, any_idx, chosen;
   logic                 hi_found, found;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - COUNT_W - INDEX_W - 1){1'b0}},
                        rsp_cnt_ff, rsp_idx_ff, rsp_acc_ff};

   // servers in use: zero acts as one, clamp to the built count
   always_comb begin
      if (nsrv_ff == '0) begin
         k_wide = 7'd1;
      end else if (7'(nsrv_ff) > 7'(MAX_SERVERS)) begin
         k_wide = 7'(MAX_SERVERS);
      end else begin
         k_wide = 7'(nsrv_ff);
      end
      k = CNT_W'(k_wide);
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_pop    = (state_ff == S_IDLE) && q_valid;

   // first free server at or above start, else lowest free one
   always_comb begin
      hi_idx   = '0;
      any_idx  = '0;
      hi_found = 1'b0;
      for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            any_idx = SRV_W'(i);
            if (SRV_W'(i) >= start_ff) begin
               hi_idx   = SRV_W'(i);
               hi_found = 1'b1;
            end
         end
      end
      chosen = hi_found ? hi_idx : any_idx;
      found  = |free_ff;
   end

   // single read port on the counts
   assign rd_idx    = (state_ff == S_PICK) ? chosen : scan_ff;
   assign count_rd  = count_ff[rd_idx];
   assign count_inc = (count_rd == COUNT_MAX) ? count_rd : count_rd + COUNT_W'(1);

   always_comb begin
      state_in    = state_ff;
      nsrv_in     = nsrv_ff;
      finish_in   = finish_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      newfin_in   = newfin_ff;
      last_in     = last_ff;
      free_in     = free_ff;
      start_in    = start_ff;
      scan_in     = scan_ff;
      best_in     = best_ff;
      last_idx_in = last_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_valid) begin
         nsrv_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               newfin_in = q_finish;
               last_in   = q_item.last;
               for (int i = 0; i < MAX_SERVERS; i++) begin
                  free_in[i] = (CMP_W'(finish_ff[i]) <= CMP_W'(q_item.arrival)) &&
                               (CNT_W'(i) < k);
               end
               start_in = (CNT_W'(ptr_ff) < k) ? ptr_ff : '0;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DISPATCH;
               rsp_acc_in   = found;
               rsp_idx_in   = found ? INDEX_W'(chosen) : '0;
               rsp_cnt_in   = found ? count_inc : '0;
               rsp_last_in  = !last_ff;
               ptr_in = (CNT_W'(start_ff) + CNT_W'(1) >= k) ? '0 : start_ff + SRV_W'(1);
               if (found) begin
                  finish_in[chosen] = newfin_ff;
                  count_in[chosen]  = count_inc;
               end
               if (last_ff) begin
                  scan_in     = '0;
                  best_in     = '0;
                  last_idx_in = '0;
                  state_in    = S_MAX;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_MAX: begin
            // >= keeps the highest index holding the maximum
            if (count_rd >= best_ff) begin
               best_in     = count_rd;
               last_idx_in = scan_ff;
            end
            if (CNT_W'(scan_ff) == k - CNT_W'(1)) begin
               scan_in  = '0;
               state_in = S_LIST;
            end else begin
               scan_in = scan_ff + SRV_W'(1);
            end
         end
         S_LIST: begin
            if (count_rd == best_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_REPORT;
                  rsp_acc_in   = 1'b1;
                  rsp_idx_in   = INDEX_W'(scan_ff);
                  rsp_cnt_in   = count_rd;
                  rsp_last_in  = (scan_ff == last_idx_ff);
                  if (scan_ff == last_idx_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     scan_in = scan_ff + SRV_W'(1);
                  end
               end
            end else begin
               scan_in = scan_ff + SRV_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nsrv_ff      <= NSRV_RESET;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_SERVERS; i++) begin
            finish_ff[i] <= '0;
            count_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         nsrv_ff      <= nsrv_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         finish_ff    <= finish_in;
         count_ff     <= count_in;
      end
      newfin_ff   <= newfin_in;
      last_ff     <= last_in;
      free_ff     <= free_in;
      start_ff    <= start_in;
      scan_ff     <= scan_in;
      best_ff     <= best_in;
      last_idx_ff <= last_idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_report_accepted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_REPORT) |-> rsp_acc_ff)
      else $error("report entry not flagged accepted");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_DISPATCH && !rsp_acc_ff) |->
         (rsp_idx_ff == '0 && rsp_cnt_ff == '0))
      else $error("dropped item carries server data");

   a_report_is_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_REPORT) |-> rsp_cnt_ff == best_ff)
      else $error("report count differs from maximum");

   a_list_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST) |-> scan_ff <= last_idx_ff)
      else $error("listing ran past last busiest server");

endmodule

FILE: src/round_robin_server_dispatcher.sv
// channel | direction | handshake             | payload
// req     | in        | req_tvalid/req_tready | tdata arrival_time, load_time; tlast last_request
// rsp     | out       | rsp_tvalid/rsp_tready | tdata accepted, server_index, served_count;
//         |           |                       | tuser kind; tlast last_of_run
// csr     | in        | csr_valid/csr_ready   | csr_wdata num_servers
//
// In the back end, S_IDLE registers the free-server compare and S_PICK picks and updates.
// A request with last set then adds two passes through the single count port:
// a full pass for the maximum, then a listing pass that ends at the last busiest server.
// Reset clears all finish times, counts and the pointer and sets num_servers to 16.
// A 2-item queue takes requests while the back end works; a result waiting in the output
// register holds the pick and listing steps until it is taken.
module round_robin_server_dispatcher #(
   parameter int MAX_SERVERS = rrsd_pkg::DEF_MAX_SERVERS,
   parameter int TIME_BITS   = rrsd_pkg::DEF_TIME_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [30:0] arrival_time, [61:31] load_time, [63:62] zero
   input  logic [rrsd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] accepted, [4:1] server_index, [36:5] served_count, [39:37] zero
   output logic [rrsd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] kind
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rrsd_pkg::NSRV_W-1:0]       csr_wdata
);
   import rrsd_pkg::*;

   logic                 q_valid;
   logic                 q_pop;
   front_item_type       q_item;
   logic [TIME_BITS-1:0] q_finish;

   rrsd_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .q_finish   (q_finish)
   );

   rrsd_back #(
      .MAX_SERVERS (MAX_SERVERS),
      .TIME_BITS   (TIME_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .q_finish   (q_finish),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
